// ===== sv/gai_pkg.sv =====
// Shared types and constants of the gyro attitude integrator.
// Holds the controller-to-datapath command struct, register indexes and reset values.
// No dependencies.
package gai_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;

  // Register indexes on the configuration channel.
  localparam logic [1:0] CFG_RATE_GAIN    = 2'd0;
  localparam logic [1:0] CFG_TIME_STEP    = 2'd1;
  localparam logic [1:0] CFG_FILTER_ALPHA = 2'd2;

  localparam logic [15:0] RATE_GAIN_RST    = 16'd3996;
  localparam logic [15:0] TIME_STEP_RST    = 16'd1311;
  localparam logic [15:0] FILTER_ALPHA_RST = 16'd64225;

  // Bias reset values in Q16.8.
  localparam logic signed [23:0] BIAS_X_RST = 24'sd2048;
  localparam logic signed [23:0] BIAS_Y_RST = -24'sd4608;
  localparam logic signed [23:0] BIAS_Z_RST = 24'sd8960;

  // 90 / 63.7 in Q.16.
  localparam logic [16:0] OUT_SCALE = 17'd92594;

  // Division by 20 is done as (x >> 2) * ceil(2^26 / 5) >> 26, exact for x below 2^23.
  localparam logic [23:0] DIV5_RECIP = 24'd13421773;
  localparam int          DIV5_SHIFT = 26;

  typedef enum logic [2:0] {
    MK_NONE,
    MK_BIAS,
    MK_RATE,
    MK_STEP,
    MK_HPF,
    MK_OUT
  } mul_kind_t;

  typedef enum logic [2:0] {
    WK_NONE,
    WK_BIAS,
    WK_RATE,
    WK_ACC,
    WK_HPF,
    WK_ANG
  } wr_kind_t;

  typedef struct packed {
    logic      load;
    logic      deliver;
    mul_kind_t mul_kind;
    logic [1:0] mul_axis;
    wr_kind_t  wr_kind;
    logic [1:0] wr_axis;
  } dp_cmd_t;

endpackage

// ===== sv/gai_ctrl.sv =====
// Sequencer of the gyro attitude integrator.
// Steps the shared multiplier through the calibrate and integrate schedules.
// Depends on gai_pkg.
module gai_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_op,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output gai_pkg::dp_cmd_t cmd
);
  import gai_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAL,
    S_INT,
    S_DLV
  } state_t;

  localparam logic [3:0] LAST_CAL_STEP = 4'd3;
  localparam logic [3:0] LAST_INT_STEP = 4'd10;

  state_t     state_r;
  logic [3:0] step_r;
  logic       out_valid_r;
  logic       slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    cmd          = '0;
    cmd.mul_kind = MK_NONE;
    cmd.wr_kind  = WK_NONE;
    case (state_r)
      S_IDLE: cmd.load = in_tvalid;
      S_CAL: begin
        case (step_r)
          4'd0: begin
            cmd.mul_kind = MK_BIAS; cmd.mul_axis = 2'd0;
          end
          4'd1: begin
            cmd.mul_kind = MK_BIAS; cmd.mul_axis = 2'd1;
            cmd.wr_kind  = WK_BIAS; cmd.wr_axis  = 2'd0;
          end
          4'd2: begin
            cmd.mul_kind = MK_BIAS; cmd.mul_axis = 2'd2;
            cmd.wr_kind  = WK_BIAS; cmd.wr_axis  = 2'd1;
          end
          4'd3: begin
            cmd.wr_kind = WK_BIAS; cmd.wr_axis = 2'd2;
          end
          default: ;
        endcase
      end
      S_INT: begin
        // Each step issues one product and retires the one issued by the step before.
        case (step_r)
          4'd0: begin
            cmd.mul_kind = MK_RATE; cmd.mul_axis = 2'd0;
          end
          4'd1: begin
            cmd.mul_kind = MK_RATE; cmd.mul_axis = 2'd1;
            cmd.wr_kind  = WK_RATE; cmd.wr_axis  = 2'd0;
          end
          4'd2: begin
            cmd.mul_kind = MK_RATE; cmd.mul_axis = 2'd2;
            cmd.wr_kind  = WK_RATE; cmd.wr_axis  = 2'd1;
          end
          4'd3: begin
            cmd.mul_kind = MK_STEP; cmd.mul_axis = 2'd0;
            cmd.wr_kind  = WK_RATE; cmd.wr_axis  = 2'd2;
          end
          4'd4: begin
            cmd.mul_kind = MK_STEP; cmd.mul_axis = 2'd1;
            cmd.wr_kind  = WK_ACC;  cmd.wr_axis  = 2'd0;
          end
          4'd5: begin
            cmd.mul_kind = MK_STEP; cmd.mul_axis = 2'd2;
            cmd.wr_kind  = WK_ACC;  cmd.wr_axis  = 2'd1;
          end
          4'd6: begin
            cmd.mul_kind = MK_HPF;
            cmd.wr_kind  = WK_ACC;  cmd.wr_axis  = 2'd2;
          end
          4'd7: begin
            cmd.mul_kind = MK_OUT;  cmd.mul_axis = 2'd0;
            cmd.wr_kind  = WK_HPF;
          end
          4'd8: begin
            cmd.mul_kind = MK_OUT;  cmd.mul_axis = 2'd1;
            cmd.wr_kind  = WK_ANG;  cmd.wr_axis  = 2'd0;
          end
          4'd9: begin
            cmd.mul_kind = MK_OUT;  cmd.mul_axis = 2'd2;
            cmd.wr_kind  = WK_ANG;  cmd.wr_axis  = 2'd1;
          end
          4'd10: begin
            cmd.wr_kind = WK_ANG; cmd.wr_axis = 2'd2;
          end
          default: ;
        endcase
      end
      S_DLV: cmd.deliver = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.deliver) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          step_r <= '0;
          if (in_tvalid) begin
            state_r <= in_op ? S_INT : S_CAL;
          end
        end
        S_CAL: begin
          step_r <= step_r + 4'd1;
          if (step_r == LAST_CAL_STEP) begin
            state_r <= S_IDLE;
          end
        end
        S_INT: begin
          step_r <= step_r + 4'd1;
          if (step_r == LAST_INT_STEP) begin
            state_r <= S_DLV;
          end
        end
        S_DLV: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/gai_datapath.sv =====
// Datapath of the gyro attitude integrator: one shared registered multiplier,
// bias, angle and filter state, configuration registers and the result register.
// Depends on gai_pkg; driven by gai_ctrl commands.
module gai_datapath #(
  parameter int ANGLE_FRAC_BITS = gai_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gai_pkg::dp_cmd_t cmd,
  input  logic [47:0]      in_tdata,
  input  logic             cfg_valid,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic [127:0]     out_tdata
);
  import gai_pkg::*;

  localparam int AW      = (ANGLE_FRAC_BITS + 18 > 35) ? ANGLE_FRAC_BITS + 18 : 35;
  localparam int BW      = 24;
  localparam int PW      = AW + BW;
  localparam int STEP_SH = 32 - ANGLE_FRAC_BITS;

  localparam logic signed [PW-1:0] S32_MAX = PW'(33'sh0_7fff_ffff);
  localparam logic signed [PW-1:0] S32_MIN = PW'(33'sh1_8000_0000);
  localparam logic signed [47:0]   ACC_LIM = 48'(64'sd1 << (ANGLE_FRAC_BITS + 16));

  logic signed [15:0] samp_r  [3];
  logic signed [23:0] bias_r  [3];
  logic signed [47:0] acc_r   [3];
  logic signed [31:0] rate_r  [3];
  logic signed [31:0] ang_r   [3];
  logic signed [31:0] hpf_in_r;
  logic signed [31:0] hpf_out_r;
  logic signed [PW-1:0] prod_r;
  logic               neg_r;
  logic [15:0]        gain_r;
  logic [15:0]        tstep_r;
  logic [15:0]        alpha_r;
  logic [127:0]       out_r;

  logic signed [24:0] d_mul;
  logic [24:0]        d_abs;
  logic signed [33:0] hp_sum;
  logic signed [47:0] acc_cl;
  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic [20:0]        quot;
  logic signed [23:0] quot_s;
  logic signed [23:0] bias_nxt;
  logic signed [PW-1:0] prod_step;
  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_nxt;
  logic signed [31:0] rate_nxt;
  logic signed [31:0] hpf_nxt;
  logic signed [31:0] ang_nxt;

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = {1'b0, {31{1'b1}}};
    end else if (v < S32_MIN) begin
      r = {1'b1, 31'b0};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    d_mul  = $signed({samp_r[cmd.mul_axis][15], samp_r[cmd.mul_axis], 8'b0})
           - $signed({bias_r[cmd.mul_axis][23], bias_r[cmd.mul_axis]});
    d_abs  = d_mul[24] ? 25'(-d_mul) : d_mul;
    hp_sum = 34'(hpf_out_r) + 34'(rate_r[2]) - 34'(hpf_in_r);
    if (acc_r[cmd.mul_axis] > ACC_LIM) begin
      acc_cl = ACC_LIM;
    end else if (acc_r[cmd.mul_axis] < -ACC_LIM) begin
      acc_cl = -ACC_LIM;
    end else begin
      acc_cl = acc_r[cmd.mul_axis];
    end
    op_a = '0;
    op_b = '0;
    case (cmd.mul_kind)
      MK_BIAS: begin
        op_a = AW'($signed({1'b0, DIV5_RECIP}));
        op_b = $signed({1'b0, d_abs[24:2]});
      end
      MK_RATE: begin
        op_a = AW'(d_mul);
        op_b = $signed({8'b0, gain_r});
      end
      MK_STEP: begin
        op_a = AW'(rate_r[cmd.mul_axis]);
        op_b = $signed({8'b0, tstep_r});
      end
      MK_HPF: begin
        op_a = AW'(hp_sum);
        op_b = $signed({8'b0, alpha_r});
      end
      MK_OUT: begin
        op_a = acc_cl[AW-1:0];
        op_b = $signed({7'b0, OUT_SCALE});
      end
      default: ;
    endcase
  end

  // Post-processing of the product issued in the previous cycle.
  always_comb begin
    quot      = prod_r[DIV5_SHIFT +: 21];
    quot_s    = neg_r ? -$signed({3'b0, quot}) : $signed({3'b0, quot});
    bias_nxt  = bias_r[cmd.wr_axis] + quot_s;
    prod_step = prod_r >>> STEP_SH;
    acc_sum   = {acc_r[cmd.wr_axis][47], acc_r[cmd.wr_axis]} + $signed(prod_step[48:0]);
    if (acc_sum[48] != acc_sum[47]) begin
      acc_nxt = acc_sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_nxt = acc_sum[47:0];
    end
    rate_nxt = sat32(prod_r >>> 8);
    hpf_nxt  = sat32(prod_r >>> 16);
    ang_nxt  = sat32(prod_r >>> ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= RATE_GAIN_RST;
      tstep_r   <= TIME_STEP_RST;
      alpha_r   <= FILTER_ALPHA_RST;
      bias_r[0] <= BIAS_X_RST;
      bias_r[1] <= BIAS_Y_RST;
      bias_r[2] <= BIAS_Z_RST;
      acc_r[0]  <= '0;
      acc_r[1]  <= '0;
      acc_r[2]  <= '0;
      hpf_in_r  <= '0;
      hpf_out_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RATE_GAIN:    gain_r  <= cfg_data;
          CFG_TIME_STEP:    tstep_r <= cfg_data;
          CFG_FILTER_ALPHA: alpha_r <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.wr_kind)
        WK_BIAS: bias_r[cmd.wr_axis] <= bias_nxt;
        WK_ACC:  acc_r[cmd.wr_axis]  <= acc_nxt;
        WK_HPF: begin
          hpf_in_r  <= rate_r[2];
          hpf_out_r <= hpf_nxt;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(op_a) * PW'(op_b);
    neg_r  <= d_mul[24];
    if (cmd.load) begin
      samp_r[0] <= in_tdata[15:0];
      samp_r[1] <= in_tdata[31:16];
      samp_r[2] <= in_tdata[47:32];
    end
    case (cmd.wr_kind)
      WK_RATE: rate_r[cmd.wr_axis] <= rate_nxt;
      WK_ANG:  ang_r[cmd.wr_axis]  <= ang_nxt;
      default: ;
    endcase
    if (cmd.deliver) begin
      out_r <= {hpf_out_r, ang_r[2], ang_r[1], ang_r[0]};
    end
  end

  assign out_tdata = out_r;

endmodule

// ===== sv/gyro_attitude_integrator_unit.sv =====
// Top level of the gyro attitude integrator: sequencer plus shared-multiplier datapath.
// Depends on gai_pkg, gai_ctrl and gai_datapath.
//
// Usage: a transaction on the in_ channel carries one raw three-axis gyro sample with
// the op flag in in_tuser. With op 0 the per-axis bias estimates move a twentieth of
// the way toward the sample and nothing is returned. With op 1 the bias-corrected
// rates are integrated into the angle accumulators, the z rate is high-pass filtered
// and one out_ transaction returns roll, pitch, yaw and the filtered yaw rate.
// The schedules are set by the single multiplier, registered after each product: a
// calibrate sample takes 3 products and the block is ready again once it is done; an
// integrate sample takes 10 products and the next sample is accepted only after its
// result has been handed to the output register.
// The result sits in an output register; while the receiver stalls the block still
// accepts and processes calibrate samples and runs an integrate sample up to its
// delivery step, where it waits until the output register is free.
// Reset (synchronous, rst_n low) restores register defaults, the bias estimates,
// zeroes the angle accumulators and filter state and drops out_tvalid.
// The cfg_ channel is always ready and must only be written while the block is idle.
module gyro_attitude_integrator_unit #(
  parameter int ANGLE_FRAC_BITS = gai_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // rate_x [15:0], rate_y [31:16], rate_z [47:32]
  input  logic [0:0]   in_tuser,   // op [0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle, yaw_rate_filtered
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import gai_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  gai_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gai_datapath #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata)
  );

  // A calibrate transaction never produces a result.
  ap_cal_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser[0]) |=>
      !$rose(out_tvalid) ##1 !$rose(out_tvalid) ##1 !$rose(out_tvalid)
      ##1 !$rose(out_tvalid))
    else $error("calibrate transaction produced a result");

  // The block works on one sample at a time.
  ap_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a sample is in progress");

  // A result only appears at the end of an integrate schedule.
  ap_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while the block was idle");

endmodule

// ===== tb/gai_attitude_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the gyro attitude integrator. It mirrors the bias, angle and filter state,
// predicts every out_ transaction and compares it field by field. Uses gai_pkg for the
// register indexes and reset values.
module gai_attitude_checker #(
  parameter int ANGLE_FRAC_BITS = gai_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [47:0]  in_tdata,   // rate_x [15:0], rate_y [31:16], rate_z [47:32]
  input  logic [0:0]   in_tuser,   // op [0]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // roll_angle, pitch_angle, yaw_angle, yaw_rate_filtered
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending_count
);
  import gai_pkg::*;

  localparam logic   OP_CALIBRATE = 1'b0;
  localparam longint I32_MAX      = 64'sd2147483647;
  localparam longint I32_MIN      = -64'sd2147483648;
  localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF;
  localparam longint ACC_MIN      = -ACC_MAX - 1;
  localparam longint BIAS_MAX     = 64'sd8388607;
  localparam longint BIAS_MIN     = -64'sd8388608;
  localparam longint DEG_SCALE    = 64'sd92594;  // 90 / 63.7 in Q.16

  // The first member lands in the top bits, so roll sits at [31:0].
  typedef struct packed {
    logic [31:0] yaw_rate;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] roll;
  } attitude_t;

  logic [15:0]        gain_q;
  logic [15:0]        step_q;
  logic [15:0]        alpha_q;
  logic signed [23:0] bias [3];
  longint             angle_acc [3];
  longint             hpf_in;
  longint             hpf_out;
  attitude_t          attitude_q [$];
  attitude_t          want;
  attitude_t          got;
  int                 errs = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [23:0] bias_track(input logic signed [23:0] b,
                                                    input logic signed [15:0] s);
    longint d;
    d = longint'(s) * 256 - longint'(b);
    // Integer division truncates toward zero, so the bias never overshoots the sample.
    return 24'(clamp(longint'(b) + d / 20, BIAS_MIN, BIAS_MAX));
  endfunction

  function automatic longint dps_rate(input logic signed [15:0] s,
                                      input logic signed [23:0] b);
    longint c;
    c = longint'(s) * 256 - longint'(b);
    return clamp((c * longint'(gain_q)) >>> 8, I32_MIN, I32_MAX);
  endfunction

  function automatic logic [31:0] scaled_angle(input longint acc);
    longint lim;
    longint a;
    lim = longint'(1) <<< (ANGLE_FRAC_BITS + 16);
    a = clamp(acc, -lim, lim);
    return 32'(clamp((a * DEG_SCALE) >>> ANGLE_FRAC_BITS, I32_MIN, I32_MAX));
  endfunction

  task automatic process_sample(input logic op, input logic [47:0] raw);
    logic signed [15:0] s [3];
    longint             r [3];
    longint             hp;
    attitude_t          e;
    for (int k = 0; k < 3; k++) s[k] = raw[16*k +: 16];
    if (op == OP_CALIBRATE) begin
      for (int k = 0; k < 3; k++) bias[k] = bias_track(bias[k], s[k]);
    end else begin
      for (int k = 0; k < 3; k++) r[k] = dps_rate(s[k], bias[k]);
      hp = hpf_out + r[2] - hpf_in;
      hp = clamp((hp * longint'(alpha_q)) >>> 16, I32_MIN, I32_MAX);
      hpf_in = r[2];
      hpf_out = hp;
      // Yaw integrates the unfiltered z rate.
      for (int k = 0; k < 3; k++) begin
        angle_acc[k] = clamp(angle_acc[k] + ((r[k] * longint'(step_q)) >>> (32 - ANGLE_FRAC_BITS)),
                             ACC_MIN, ACC_MAX);
      end
      e.roll = scaled_angle(angle_acc[0]);
      e.pitch = scaled_angle(angle_acc[1]);
      e.yaw = scaled_angle(angle_acc[2]);
      e.yaw_rate = hp[31:0];
      attitude_q.push_back(e);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errs++;
      if (errs <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
                 $signed(exp_val), $signed(act_val));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_q = RATE_GAIN_RST;
      step_q = TIME_STEP_RST;
      alpha_q = FILTER_ALPHA_RST;
      bias[0] = BIAS_X_RST;
      bias[1] = BIAS_Y_RST;
      bias[2] = BIAS_Z_RST;
      for (int k = 0; k < 3; k++) angle_acc[k] = 0;
      hpf_in = 0;
      hpf_out = 0;
      attitude_q.delete();
    end else begin
      // A result leaving now belongs to an earlier sample, so compare before predicting.
      if (out_tvalid && out_tready) begin
        if (attitude_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: result transaction with none expected", $realtime);
        end else begin
          want = attitude_q.pop_front();
          got = out_tdata;
          check_field("roll_angle", want.roll, got.roll);
          check_field("pitch_angle", want.pitch, got.pitch);
          check_field("yaw_angle", want.yaw, got.yaw);
          check_field("yaw_rate_filtered", want.yaw_rate, got.yaw_rate);
        end
      end
      if (in_tvalid && in_tready) process_sample(in_tuser[0], in_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_RATE_GAIN:    gain_q = cfg_data;
          CFG_TIME_STEP:    step_q = cfg_data;
          CFG_FILTER_ALPHA: alpha_q = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= errs;
    pending_count <= attitude_q.size();
  end

endmodule

// ===== tb/tb_gyro_attitude_integrator_unit.sv =====
`timescale 1ns / 100ps
// Top of the gyro attitude integrator testbench: clock, reset, sample and register stimulus,
// random receiver stalls, a stall watchdog and the verdict.
// Depends on gai_pkg, gyro_attitude_integrator_unit and gai_attitude_checker.
module tb_gyro_attitude_integrator_unit;
  import gai_pkg::*;

  localparam int         AFB           = ANGLE_FRAC_BITS_DEF;
  localparam logic       OP_CALIBRATE  = 1'b0;
  localparam logic       OP_INTEGRATE  = 1'b1;
  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam int         RANDOM_BLOCKS = 4;
  localparam int         BLOCK_ITEMS   = 117;
  localparam int         DRAIN_CYCLES  = 30;
  localparam int         STALL_LIMIT   = 5000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;
  logic [0:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [15:0]  cfg_data;

  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int fail_count;
  int pending_count;
  int quiet_cycles;

  gyro_attitude_integrator_unit #(
    .ANGLE_FRAC_BITS(AFB)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gai_attitude_checker #(
    .ANGLE_FRAC_BITS(AFB)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Ends the run when no transaction of any kind has completed for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 400)) - 16'd200;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_reg(input logic [15:0] rst_val);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return rst_val;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Called at a falling edge; leaves in_tvalid high so back-to-back samples need no gap.
  task automatic send_sample(input logic op, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
    while ($urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] gain, input logic [15:0] step,
                              input logic [15:0] alpha);
    write_reg(CFG_RATE_GAIN, gain);
    write_reg(CFG_TIME_STEP, step);
    write_reg(CFG_FILTER_ALPHA, alpha);
    write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
  endtask

  // Waits until every expected result has left, then lets a trailing calibrate sample finish.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int ph;
    int blk;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and bias tracking under the reset register values.
    send_sample(OP_INTEGRATE, 16'h0000, 16'h0000, 16'h0000);
    send_sample(OP_INTEGRATE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(OP_INTEGRATE, 16'h8000, 16'h8000, 16'h8000);
    send_sample(OP_CALIBRATE, 16'h7FFF, 16'h8000, 16'h0000);
    send_sample(OP_CALIBRATE, 16'h8000, 16'h7FFF, 16'hFFFF);
    send_sample(OP_INTEGRATE, 16'hFFFF, 16'h0001, 16'h8000);
    send_sample(OP_CALIBRATE, 16'h0008, 16'hFFEE, 16'h0023);
    send_sample(OP_INTEGRATE, 16'h0008, 16'hFFEE, 16'h0023);

    // Full-scale gain and step drive rates, angles and the filter into saturation.
    settle();
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (3) send_sample(OP_INTEGRATE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (6) send_sample(OP_INTEGRATE, 16'h8000, 16'h8000, 16'h8000);
    send_sample(OP_INTEGRATE, 16'h7FFF, 16'h8000, 16'h7FFF);

    settle();
    program_regs(16'h0000, 16'h0000, 16'h0000);
    send_sample(OP_INTEGRATE, 16'h7FFF, 16'h8000, 16'h1234);
    send_sample(OP_CALIBRATE, 16'h8000, 16'h8000, 16'h8000);
    send_sample(OP_INTEGRATE, 16'h0000, 16'h0000, 16'h0000);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          in_gap_pct = 11;
          out_stall_pct = 76;
        end
        1: begin
          in_gap_pct = 76;
          out_stall_pct = 11;
        end
        default: begin
          in_gap_pct = 0;
          out_stall_pct = 0;
        end
      endcase
      for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
        settle();
        program_regs(pick_reg(RATE_GAIN_RST), pick_reg(TIME_STEP_RST),
                     pick_reg(FILTER_ALPHA_RST));
        repeat (BLOCK_ITEMS) begin
          send_sample(($urandom_range(0, 99) < 35) ? OP_CALIBRATE : OP_INTEGRATE,
                      pick_sample(), pick_sample(), pick_sample());
        end
      end
    end

    settle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
